### sv/bba_pkg.sv
// Shared types and constants of the buddy block allocator.
// Controller/datapath command and status structs, result codes.
// No dependencies.
package bba_pkg;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BADFREE = 2'd2;

	// bytes of block header added to each request
	localparam int unsigned HDR_BYTES = 2;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_CLEAR,
		DP_LOAD,
		DP_RD_NODE,
		DP_STEP,
		DP_TAKE,
		DP_SPLIT,
		DP_GRANT,
		DP_RD_TAG,
		DP_UNTAG,
		DP_RD_BUDDY,
		DP_MERGE,
		DP_RELEASE,
		DP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] st;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_free;
		logic too_big;
		logic bad_off;
		logic hit;
		logic lvl_end;
		logic at_top;
		logic k_eq_want;
		logic k_next_top;
		logic tag_bad;
		logic tag_top;
	} dp_stat_t;

endpackage

### sv/buddy_block_allocator.sv
// Top level of the binary buddy allocator.
// Instantiates bba_ctrl and bba_datapath; uses bba_pkg.
//
// A beat is taken when start is high and busy is low; its result shows on
// status/block_offset/block_order for one cycle with done high and cannot be
// held off. After reset a clearing pass over all 2^(TOP_ORDER-MIN_ORDER+1)
// free-map entries (4096 by default) holds busy high. Allocate probes
// free-map nodes in lowest-order-first, lowest-address-first order (up to
// 2^(TOP_ORDER-MIN_ORDER+1)-1 probes), then splits down to the wanted
// order; an oversized request is answered without probing. Free reads the
// order tag, then merges with each free buddy upward; a bad offset or tag
// is answered without merging. The free-map memory gives one read per cycle.
module buddy_block_allocator #(
	parameter int TOP_ORDER = 16,
	parameter int MIN_ORDER = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [15:0] req_bytes,
	input  logic [15:0] free_offset,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] block_offset,
	output logic [4:0]  block_order
);

	bba_pkg::dp_cmd_t  dp_cmd;
	bba_pkg::dp_stat_t dp_stat;

	bba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat_i(dp_stat),
		.cmd_o(dp_cmd), .busy(busy), .done(done)
	);

	bba_datapath #(.TOP_ORDER(TOP_ORDER), .MIN_ORDER(MIN_ORDER)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd_i(dp_cmd), .cmd(cmd),
		.req_bytes(req_bytes), .free_offset(free_offset), .stat_o(dp_stat),
		.status(status), .block_offset(block_offset), .block_order(block_order)
	);

endmodule

### sv/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/bba_datapath.sv
// Datapath of the buddy allocator: node/order registers, free-node map and
// order-tag memories, result registers. Uses bba_pkg and bba_ram.
module bba_datapath #(
	parameter int TOP_ORDER = 16,
	parameter int MIN_ORDER = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bba_pkg::dp_cmd_t  cmd_i,
	input  logic              cmd,
	input  logic [15:0]       req_bytes,
	input  logic [15:0]       free_offset,
	output bba_pkg::dp_stat_t stat_o,
	output logic [1:0]        status,
	output logic [15:0]       block_offset,
	output logic [4:0]        block_order
);

	localparam int LVL   = TOP_ORDER - MIN_ORDER;
	localparam int NW    = LVL + 1;
	localparam int NW1   = NW + 1;
	localparam int SW    = LVL;
	localparam int NODES = 2 ** NW;
	localparam int SLOTS = 2 ** SW;
	localparam int OW    = (TOP_ORDER > 16) ? TOP_ORDER : 16;

	logic          cmd_q;
	logic [15:0]   off_q;
	logic [4:0]    want_q;
	logic          fit_q;
	logic [NW-1:0] node_q;
	logic [4:0]    k_q;
	logic [NW-1:0] clr_q;
	logic [1:0]    res_st_q;
	logic [15:0]   res_off_q;
	logic [4:0]    res_ord_q;

	logic          fm_we, fm_wdata, fm_rdata;
	logic [NW-1:0] fm_waddr, fm_raddr;
	logic          tg_we;
	logic [4:0]    tg_wdata, tg_rdata;
	logic [SW-1:0] tg_waddr, tg_raddr;

	logic [4:0]    want_c;
	logic          fit_c;
	logic [16:0]   need_c;
	logic [SW-1:0] slot_c;
	logic [NW-1:0] buddy_c, parent_c, base_c;
	logic [OW-1:0] boff_c;

	function automatic logic [NW-1:0] lvl_base(input logic [4:0] k);
		logic [NW:0] one;
		one = NW1'(1);
		lvl_base = NW'((one << (5'(TOP_ORDER) - k)) - one);
	endfunction

	// smallest order that holds payload plus header
	always_comb begin
		need_c = 17'(req_bytes) + 17'(bba_pkg::HDR_BYTES);
		want_c = '0;
		fit_c  = 1'b0;
		for (int i = TOP_ORDER; i >= MIN_ORDER; i--) begin
			if ((64'd1 << i) >= 64'(need_c)) begin
				want_c = 5'(i);
				fit_c  = 1'b1;
			end
		end
	end

	assign slot_c   = SW'(32'(off_q) >> MIN_ORDER);
	assign buddy_c  = node_q[0] ? node_q + NW'(1) : node_q - NW'(1);
	assign parent_c = (node_q - NW'(1)) >> 1;
	assign base_c   = lvl_base(k_q);
	assign boff_c   = OW'(node_q - base_c) << k_q;

	always_comb begin
		stat_o.clr_last   = (clr_q == {NW{1'b1}});
		stat_o.is_free    = cmd_q;
		stat_o.too_big    = !fit_q;
		stat_o.bad_off    = ((32'(off_q) & ((32'd1 << MIN_ORDER) - 32'd1)) != 32'd0) ||
			((32'(off_q) >> TOP_ORDER) != 32'd0);
		stat_o.hit        = fm_rdata;
		stat_o.lvl_end    = (node_q == NW'(base_c << 1));
		stat_o.at_top     = (k_q == 5'(TOP_ORDER));
		stat_o.k_eq_want  = (k_q == want_q);
		stat_o.k_next_top = (k_q + 5'd1 == 5'(TOP_ORDER));
		stat_o.tag_bad    = (tg_rdata < 5'(MIN_ORDER)) || (tg_rdata > 5'(TOP_ORDER)) ||
			((32'(off_q) & ((32'd1 << tg_rdata) - 32'd1)) != 32'd0);
		stat_o.tag_top    = (tg_rdata == 5'(TOP_ORDER));
	end

	always_comb begin
		fm_we    = 1'b0;
		fm_waddr = node_q;
		fm_wdata = 1'b0;
		fm_raddr = node_q;
		tg_we    = 1'b0;
		tg_waddr = slot_c;
		tg_wdata = '0;
		tg_raddr = slot_c;
		case (cmd_i.op)
			bba_pkg::DP_CLEAR: begin
				// root free, everything else clear; tag slots wrap harmlessly
				fm_we    = 1'b1;
				fm_waddr = clr_q;
				fm_wdata = (clr_q == '0);
				tg_we    = 1'b1;
				tg_waddr = SW'(clr_q);
			end
			bba_pkg::DP_RD_BUDDY: fm_raddr = buddy_c;
			bba_pkg::DP_TAKE: fm_we = 1'b1;
			bba_pkg::DP_SPLIT: begin
				fm_we    = 1'b1;
				fm_waddr = NW'({node_q, 1'b0} + NW1'(2));
				fm_wdata = 1'b1;
			end
			bba_pkg::DP_GRANT: begin
				tg_we    = 1'b1;
				tg_waddr = SW'(boff_c >> MIN_ORDER);
				tg_wdata = k_q;
			end
			bba_pkg::DP_UNTAG: tg_we = 1'b1;
			bba_pkg::DP_MERGE: begin
				fm_we    = 1'b1;
				fm_waddr = buddy_c;
			end
			bba_pkg::DP_RELEASE: begin
				fm_we    = 1'b1;
				fm_wdata = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd_i.op == bba_pkg::DP_CLEAR) begin
			clr_q <= clr_q + NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd_i.op)
			bba_pkg::DP_LOAD: begin
				cmd_q  <= cmd;
				off_q  <= free_offset;
				want_q <= want_c;
				fit_q  <= fit_c;
				node_q <= lvl_base(want_c);
				k_q    <= want_c;
			end
			bba_pkg::DP_STEP: begin
				if (stat_o.lvl_end) begin
					k_q    <= k_q + 5'd1;
					node_q <= lvl_base(k_q + 5'd1);
				end else begin
					node_q <= node_q + NW'(1);
				end
			end
			bba_pkg::DP_SPLIT: begin
				node_q <= NW'({node_q, 1'b1});
				k_q    <= k_q - 5'd1;
			end
			bba_pkg::DP_UNTAG: begin
				k_q    <= tg_rdata;
				node_q <= lvl_base(tg_rdata) + NW'(32'(off_q) >> tg_rdata);
			end
			bba_pkg::DP_MERGE: begin
				node_q <= parent_c;
				k_q    <= k_q + 5'd1;
			end
			bba_pkg::DP_GRANT, bba_pkg::DP_RELEASE: begin
				res_st_q  <= bba_pkg::ST_OK;
				res_off_q <= boff_c[15:0];
				res_ord_q <= k_q;
			end
			bba_pkg::DP_RESULT: begin
				res_st_q  <= cmd_i.st;
				res_off_q <= '0;
				res_ord_q <= '0;
			end
			default: ;
		endcase
	end

	bba_ram #(.WIDTH(1), .DEPTH(NODES)) u_fmap (
		.clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
		.raddr(fm_raddr), .rdata(fm_rdata)
	);

	bba_ram #(.WIDTH(5), .DEPTH(SLOTS)) u_tag (
		.clk(clk), .we(tg_we), .waddr(tg_waddr), .wdata(tg_wdata),
		.raddr(tg_raddr), .rdata(tg_rdata)
	);

	assign status       = res_st_q;
	assign block_offset = res_off_q;
	assign block_order  = res_ord_q;

endmodule

### sv/bba_ctrl.sv
// Controller state machine of the buddy allocator: sequences clearing,
// level search, splitting and merging. Uses bba_pkg.
module bba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  bba_pkg::dp_stat_t stat_i,
	output bba_pkg::dp_cmd_t  cmd_o,
	output logic              busy,
	output logic              done
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CHK0, S_A_RD, S_A_CHK, S_A_SPLIT,
		S_F_CHK, S_M_RD, S_M_CHK, S_F_SET
	} state_t;

	state_t state_q, state_d;
	logic   done_q, done_d;

	always_comb begin
		state_d   = state_q;
		done_d    = 1'b0;
		cmd_o.op  = bba_pkg::DP_NOP;
		cmd_o.st  = bba_pkg::ST_OK;
		case (state_q)
			S_CLEAR: begin
				cmd_o.op = bba_pkg::DP_CLEAR;
				if (stat_i.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd_o.op = bba_pkg::DP_LOAD;
					state_d  = S_CHK0;
				end
			end
			S_CHK0: begin
				if (stat_i.is_free) begin
					if (stat_i.bad_off) begin
						cmd_o.op = bba_pkg::DP_RESULT;
						cmd_o.st = bba_pkg::ST_BADFREE;
						state_d  = S_IDLE;
						done_d   = 1'b1;
					end else begin
						cmd_o.op = bba_pkg::DP_RD_TAG;
						state_d  = S_F_CHK;
					end
				end else if (stat_i.too_big) begin
					cmd_o.op = bba_pkg::DP_RESULT;
					cmd_o.st = bba_pkg::ST_NOSPACE;
					state_d  = S_IDLE;
					done_d   = 1'b1;
				end else begin
					cmd_o.op = bba_pkg::DP_RD_NODE;
					state_d  = S_A_CHK;
				end
			end
			S_A_RD: begin
				cmd_o.op = bba_pkg::DP_RD_NODE;
				state_d  = S_A_CHK;
			end
			S_A_CHK: begin
				if (stat_i.hit) begin
					cmd_o.op = bba_pkg::DP_TAKE;
					state_d  = S_A_SPLIT;
				end else if (stat_i.lvl_end && stat_i.at_top) begin
					cmd_o.op = bba_pkg::DP_RESULT;
					cmd_o.st = bba_pkg::ST_NOSPACE;
					state_d  = S_IDLE;
					done_d   = 1'b1;
				end else begin
					cmd_o.op = bba_pkg::DP_STEP;
					state_d  = S_A_RD;
				end
			end
			S_A_SPLIT: begin
				if (stat_i.k_eq_want) begin
					cmd_o.op = bba_pkg::DP_GRANT;
					state_d  = S_IDLE;
					done_d   = 1'b1;
				end else begin
					cmd_o.op = bba_pkg::DP_SPLIT;
				end
			end
			S_F_CHK: begin
				if (stat_i.tag_bad) begin
					cmd_o.op = bba_pkg::DP_RESULT;
					cmd_o.st = bba_pkg::ST_BADFREE;
					state_d  = S_IDLE;
					done_d   = 1'b1;
				end else begin
					cmd_o.op = bba_pkg::DP_UNTAG;
					state_d  = stat_i.tag_top ? S_F_SET : S_M_RD;
				end
			end
			S_M_RD: begin
				cmd_o.op = bba_pkg::DP_RD_BUDDY;
				state_d  = S_M_CHK;
			end
			S_M_CHK: begin
				if (stat_i.hit) begin
					cmd_o.op = bba_pkg::DP_MERGE;
					state_d  = stat_i.k_next_top ? S_F_SET : S_M_RD;
				end else begin
					state_d = S_F_SET;
				end
			end
			S_F_SET: begin
				cmd_o.op = bba_pkg::DP_RELEASE;
				state_d  = S_IDLE;
				done_d   = 1'b1;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == S_CHK0)
		else $error("accepted beat did not enter check state");
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) != S_IDLE && $past(state_q) != S_CLEAR)
		else $error("result strobe without work");
	a_split_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_A_SPLIT && !stat_i.k_eq_want |=> state_q == S_A_SPLIT)
		else $error("split left before reaching wanted order");

endmodule

### dv/bba_checker.sv
// Result checker for the buddy block allocator: tracks its own copy of the
// free-node map and order tags, predicts each beat and compares on done.
// Uses bba_pkg status codes.
module bba_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        cmd,
	input  logic [15:0] req_bytes,
	input  logic [15:0] free_offset,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [15:0] block_offset,
	input  logic [4:0]  block_order,
	output int          errors,
	output int          pending
);

	localparam int TOP = 16;
	localparam int MIN = 5;
	localparam int LEAVES = 1 << (TOP - MIN);
	localparam int NODES = 2 * LEAVES - 1;

	typedef struct packed {
		logic [1:0]  st;
		logic [15:0] off;
		logic [4:0]  ord;
	} grant_t;

	bit       node_free[NODES];
	bit [4:0] slot_order[LEAVES];
	grant_t   grants_due[$];

	function automatic int lvl_base(int k);
		return (1 << (TOP - k)) - 1;
	endfunction

	function automatic grant_t predict_alloc(int req);
		int need, want, k, node, i;
		bit hit;
		grant_t g;
		need = req + bba_pkg::HDR_BYTES;
		want = MIN;
		hit = 0;
		node = 0;
		g = '{bba_pkg::ST_NOSPACE, 16'd0, 5'd0};
		while (want <= TOP && (1 << want) < need) want++;
		if (want > TOP) return g;
		for (k = want; k <= TOP; k++) begin
			for (i = 0; i < (1 << (TOP - k)); i++) begin
				if (node_free[lvl_base(k) + i]) begin
					node = lvl_base(k) + i;
					hit = 1;
					break;
				end
			end
			if (hit) break;
		end
		if (!hit) return g;
		node_free[node] = 0;
		while (k > want) begin
			node_free[2 * node + 2] = 1;
			node = 2 * node + 1;
			k--;
		end
		g.off = 16'((node - lvl_base(k)) << k);
		g.ord = 5'(k);
		g.st = bba_pkg::ST_OK;
		slot_order[g.off >> MIN] = 5'(k);
		return g;
	endfunction

	function automatic grant_t predict_free(int off);
		int slot, k, node, bud;
		grant_t g;
		g = '{bba_pkg::ST_BADFREE, 16'd0, 5'd0};
		slot = off >> MIN;
		if ((off % (1 << MIN)) != 0 || slot >= LEAVES) return g;
		k = slot_order[slot];
		if (k < MIN || k > TOP || (off % (1 << k)) != 0) return g;
		slot_order[slot] = 0;
		node = lvl_base(k) + (off >> k);
		while (k < TOP) begin
			bud = (node % 2 == 1) ? node + 1 : node - 1;
			if (!node_free[bud]) break;
			node_free[bud] = 0;
			node = (node - 1) / 2;
			k++;
		end
		node_free[node] = 1;
		g.st = bba_pkg::ST_OK;
		g.off = 16'((node - lvl_base(k)) << k);
		g.ord = 5'(k);
		return g;
	endfunction

	task automatic report(string what);
		$display("%0t mismatch: %s", $time, what);
		errors++;
	endtask

	initial begin
		errors = 0;
		foreach (node_free[i]) node_free[i] = 0;
		foreach (slot_order[i]) slot_order[i] = 0;
		node_free[0] = 1;
	end

	assign pending = grants_due.size();

	always @(posedge clk) begin
		grant_t exp_g;
		if (arst_n) begin
			// result of the previous beat is compared before a new one is queued
			if (done) begin
				if (grants_due.size() == 0) begin
					report("result with nothing outstanding");
				end else begin
					exp_g = grants_due.pop_front();
					if (status !== exp_g.st)
						report($sformatf("status %0d want %0d", status, exp_g.st));
					if (block_offset !== exp_g.off)
						report($sformatf("offset %h want %h", block_offset, exp_g.off));
					if (block_order !== exp_g.ord)
						report($sformatf("order %0d want %0d", block_order, exp_g.ord));
				end
			end
			if (start && !busy)
				grants_due = {grants_due,
					cmd ? predict_free(free_offset) : predict_alloc(req_bytes)};
		end
	end
endmodule

### dv/tb_top.sv
// Top of the buddy block allocator testbench: clock, reset, stimulus and verdict.
// Depends on bba_pkg, buddy_block_allocator and bba_checker.
module tb_top;

	localparam int STALL_LIMIT = 60000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        cmd = 0;
	logic [15:0] req_bytes = 0;
	logic [15:0] free_offset = 0;
	logic        busy, done;
	logic [1:0]  status;
	logic [15:0] block_offset;
	logic [4:0]  block_order;
	int          errors, pending;
	int          idle_cycles = 0;
	logic        inflight_cmd_q = 0;
	logic [15:0] live_blocks[$];
	logic [15:0] freed_blocks[$];

	always #10 clk = ~clk;

	buddy_block_allocator u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.req_bytes(req_bytes), .free_offset(free_offset), .done(done),
		.status(status), .block_offset(block_offset), .block_order(block_order)
	);

	bba_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.req_bytes(req_bytes), .free_offset(free_offset), .done(done),
		.status(status), .block_offset(block_offset), .block_order(block_order),
		.errors(errors), .pending(pending)
	);

	// granted offsets feed the free stimulus; cmd may already hold the next beat
	always @(posedge clk) begin
		if (start && !busy) inflight_cmd_q <= cmd;
		if (done && status == bba_pkg::ST_OK && !inflight_cmd_q)
			live_blocks = {live_blocks, block_offset};
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// called just after a rising edge; leaves start high when the next beat follows at once
	task automatic send(logic c, logic [15:0] rb, logic [15:0] fo);
		int gap;
		cmd <= c;
		req_bytes <= rb;
		free_offset <= fo;
		start <= 1;
		forever begin
			@(negedge clk);
			if (!busy) break;
		end
		@(posedge clk);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic alloc_beat(logic [15:0] rb);
		send(1'b0, rb, 16'($urandom));
	endtask

	task automatic free_beat(logic [15:0] fo);
		send(1'b1, 16'($urandom), fo);
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		int i, sel, idx;
		logic [15:0] off;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// whole region, then nothing left, then odd, unallocated and double frees
		alloc_beat(16'd65534);
		alloc_beat(16'd0);
		free_beat(16'd1);
		free_beat(16'hFFFF);
		free_beat(16'hFFE0);
		free_beat(16'd0);
		free_beat(16'd0);
		alloc_beat(16'hFFFF);
		alloc_beat(16'd65535 - 16'd1);
		free_beat(16'd0);
		alloc_beat(16'd0);
		alloc_beat(16'd30);
		alloc_beat(16'd31);
		alloc_beat(16'd62);
		alloc_beat(16'd1000);
		alloc_beat(16'd32766);
		drain();
		// lowest grants are at 0, 32, 64, 128; free 32 first so merges cascade later
		free_beat(16'd32);
		free_beat(16'd64);
		free_beat(16'd0);
		free_beat(16'd128);
		drain();
		live_blocks.delete();

		for (i = 0; i < 1200; i++) begin
			if (i == 600) drain();
			sel = $urandom_range(0, 99);
			if (live_blocks.size() == 0 || sel < 52) begin
				sel = $urandom_range(0, 99);
				if (sel < 70) alloc_beat(16'($urandom_range(0, 300)));
				else if (sel < 90) alloc_beat(16'($urandom_range(0, 4000)));
				else if (sel < 98) alloc_beat(16'($urandom_range(0, 30000)));
				else alloc_beat(16'($urandom));
			end else if (sel < 88) begin
				idx = $urandom_range(0, live_blocks.size() - 1);
				off = live_blocks[idx];
				live_blocks.delete(idx);
				freed_blocks = {freed_blocks, off};
				if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
				free_beat(off);
			end else if (sel < 93 && freed_blocks.size() != 0) begin
				// double free, or a stale offset reused by a later grant
				free_beat(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
			end else if (sel < 97) begin
				free_beat(16'($urandom_range(0, 2047) << 5));
			end else begin
				free_beat(16'($urandom));
			end
		end
		drain();
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

### filelist.f
sv/bba_pkg.sv
sv/bba_ram.sv
sv/bba_datapath.sv
sv/bba_ctrl.sv
sv/buddy_block_allocator.sv
dv/bba_checker.sv
dv/tb_top.sv
